### rtl/core/eds_pkg.sv
// Shared constants, types and the tanh lookup table for the echo and soft-clip block.
// Depends on nothing; the table is built when the design is elaborated.
package eds_pkg;

  // Delay line geometry.
  localparam int ADDR_W      = 15;
  localparam int DELAY_DEPTH = 1 << ADDR_W;
  localparam int FILL_W      = ADDR_W + 1;

  // Tanh table geometry: a 16-bit magnitude (up to 32768) splits into index and fraction.
  localparam int TANH_BITS    = 8;
  localparam int TANH_ENTRIES = 1 << TANH_BITS;
  localparam int FRAC_W       = 15 - TANH_BITS;
  localparam int IDX_W        = TANH_BITS + 1;

  // Configuration register indexes.
  localparam logic [0:0] REG_DELAY_LENGTH = 1'b0;
  localparam logic [0:0] REG_ECHO_GAIN    = 1'b1;

  localparam logic [63:0] Q28_ONE = 64'd1 << 28;

  typedef logic [14:0] tanh_table_t [0:TANH_ENTRIES];

  // Unsigned restoring division by shift and subtract, used at elaboration only.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(y) in Q28 by its Taylor series, truncating each term, until a term vanishes.
  function automatic logic [63:0] exp_q28(input logic [63:0] y);
    logic [63:0] sum;
    logic [63:0] term;
    logic        done;
    sum  = Q28_ONE;
    term = Q28_ONE;
    done = 1'b0;
    for (int n = 1; n < 64; n++) begin
      if (!done) begin
        term = (term * y) >> 28;
        term = udiv64(term, 64'(n));
        if (term == 64'd0) begin
          done = 1'b1;
        end else begin
          sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

  // T[k] = round(32768 * (E - 1) / (E + 1)) with E = exp(2k / TANH_ENTRIES).
  function automatic tanh_table_t build_tanh_table();
    tanh_table_t tab;
    logic [63:0] y;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    for (int k = 0; k <= TANH_ENTRIES; k++) begin
      y      = (64'(k) * 64'd2 * Q28_ONE) >> TANH_BITS;
      e      = exp_q28(y);
      num    = (e - Q28_ONE) * 64'd32768;
      den    = e + Q28_ONE;
      tab[k] = 15'(udiv64(num + (den >> 1), den));
    end
    return tab;
  endfunction

  localparam tanh_table_t TANH_TABLE = build_tanh_table();

endpackage

### rtl/core/echo_delay_soft_clip.sv
// Feedforward echo with a tanh soft clipper and a running output peak.
// Depends on eds_pkg for geometry, register indexes and the tanh table.
//
// Usage:
//   Input channel in_valid/in_ready carries one signed Q1.15 sample per transfer.
//   Output channel out_valid/out_ready carries the clipped sample and the peak
//   of |out_sample| seen since reset, one result per input transfer, in order.
//   Configuration is written through cfg_we/cfg_index/cfg_data while the block
//   is idle: index 0 is delay_length, index 1 is echo_gain (unsigned Q2.14).
//   An input transfer passes through the stage 1 to 4 registers and the output
//   register before out_valid rises. Throughput is one sample per cycle while
//   the receiver takes results: the delay line memory takes one write and one
//   read per cycle, and the five-stage datapath behind it advances as one.
//   When the receiver stalls, the whole pipeline holds and in_ready drops; it
//   rises again in the cycle the waiting result is taken.
//   Reset empties the pipeline and clears the write pointer, the fill count,
//   the peak and both registers. The delay line is not swept: a fill count
//   marks which entries have been written, and the echo tap reads unwritten
//   entries as zero, so the block is ready at once after reset.
//   Feed zero samples to flush the echo tail.
module echo_delay_soft_clip
  import eds_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  output logic        [14:0] peak_level,
  input  logic               cfg_we,
  input  logic         [0:0] cfg_index,
  input  logic        [15:0] cfg_data
);

  // Configuration registers.
  logic [14:0] delay_length;
  logic [15:0] echo_gain;

  // Delay line and its bookkeeping.
  logic signed [15:0] delay_mem [0:DELAY_DEPTH-1];
  logic signed [15:0] mem_q;
  logic [ADDR_W-1:0]  wp;
  logic [ADDR_W-1:0]  rd_addr;
  logic [FILL_W-1:0]  fill;

  logic pipe_en;
  logic in_xfer;

  // Stage registers.
  logic               s1_valid, s2_valid, s3_valid, s4_valid;
  logic signed [15:0] s1_x, s2_x;
  logic               s1_use_x, s1_hit;
  logic signed [32:0] s2_prod;
  logic [IDX_W-1:0]   s3_idx;
  logic [FRAC_W-1:0]  s3_frac;
  logic               s3_neg, s4_neg;
  logic [14:0]        s4_lo;
  logic [14+FRAC_W:0] s4_prod;
  logic [14:0]        peak;

  // Combinational values between stages.
  logic signed [15:0] tap;
  logic signed [33:0] biased;
  logic signed [19:0] echo;
  logic signed [20:0] sum;
  logic signed [15:0] sat;
  logic [15:0]        mag;
  logic [IDX_W-1:0]   hi_idx;
  logic [14:0]        lo_val, hi_val, diff;
  logic [15+FRAC_W:0] rounded;
  logic [14:0]        y;
  logic [14:0]        peak_next;
  logic [15:0]        out_mag;

  // The whole pipeline moves unless a finished result is waiting.
  assign pipe_en  = !out_valid || out_ready;
  assign in_ready = pipe_en;
  assign in_xfer  = in_valid && in_ready;
  assign rd_addr  = wp - delay_length;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length <= '0;
      echo_gain    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELAY_LENGTH: delay_length <= cfg_data[14:0];
        REG_ECHO_GAIN:    echo_gain    <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Delay line memory: the new sample is written while the echo tap is read.
  // With a nonzero delay the two addresses always differ.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      delay_memory_write: delay_mem[wp] <= in_sample;
      mem_q <= delay_mem[rd_addr];
    end
  end

  // Write pointer and fill count, which stands in for clearing the line.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (in_xfer) begin
      wp <= wp + 1'b1;
      if (fill != FILL_W'(DELAY_DEPTH)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // Stage 1: hold the sample alongside the memory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pipe_en) begin
      s1_valid <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_x     <= in_sample;
      s1_use_x <= (delay_length == '0);
      s1_hit   <= (fill >= {1'b0, delay_length});
    end
  end

  // Zero delay taps the current sample; an entry not yet written reads as zero.
  assign tap = s1_use_x ? s1_x : (s1_hit ? mem_q : 16'sd0);

  // Stage 2: scale the tap by the echo gain.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (pipe_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_x    <= s1_x;
      s2_prod <= tap * $signed({1'b0, echo_gain});
    end
  end

  // Round the echo with ties up, add the dry sample and saturate.
  assign biased = {s2_prod[32], s2_prod} + 34'sd8192;
  assign echo   = biased[33:14];
  assign sum    = {{5{s2_x[15]}}, s2_x} + {echo[19], echo};

  always_comb begin
    if (sum > 21'sd32767) begin
      sat = 16'sh7fff;
    end else if (sum < -21'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[15:0];
    end
  end

  assign mag = sat[15] ? 16'(-sat) : 16'(sat);

  // Stage 3: magnitude split into table index and fraction.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (pipe_en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s3_idx  <= mag[15:FRAC_W];
      s3_frac <= mag[FRAC_W-1:0];
      s3_neg  <= sat[15];
    end
  end

  // Table lookups; the last entry stands alone at full scale.
  assign hi_idx = (s3_idx == IDX_W'(TANH_ENTRIES)) ? s3_idx : s3_idx + 1'b1;
  assign lo_val = TANH_TABLE[s3_idx];
  assign hi_val = TANH_TABLE[hi_idx];
  assign diff   = (hi_val > lo_val) ? hi_val - lo_val : 15'd0;

  // Stage 4: interpolation product.
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (pipe_en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s4_lo   <= lo_val;
      s4_prod <= diff * s3_frac;
      s4_neg  <= s3_neg;
    end
  end

  // Round the interpolated step and update the peak.
  assign rounded   = {1'b0, s4_prod} + (FRAC_W+16)'(1 << (FRAC_W - 1));
  assign y         = s4_lo + 15'(rounded >> FRAC_W);
  assign peak_next = (y > peak) ? y : peak;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      peak      <= '0;
    end else if (pipe_en) begin
      out_valid <= s4_valid;
      if (s4_valid) begin
        peak <= peak_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en && s4_valid) begin
      out_sample <= s4_neg ? -$signed({1'b0, y}) : $signed({1'b0, y});
    end
  end

  assign peak_level = peak;
  assign out_mag    = out_sample[15] ? 16'(-out_sample) : 16'(out_sample);

  // The reported peak covers the sample shown with it.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_mag <= {1'b0, peak_level})
    else $error("peak_level below the magnitude of out_sample");

  // The fill count saturates at the depth of the delay line.
  assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DELAY_DEPTH))
    else $error("delay line fill count beyond its depth");

  // Input back-pressure only ever comes from a waiting result.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without a stalled result");

endmodule

### dv/tb.sv
// Self-checking testbench for echo_delay_soft_clip: feedforward echo, tanh soft clip, peak.
// Depends on eds_pkg (register indexes and geometry) and the echo_delay_soft_clip RTL.
// A behavioural predictor in this file works out every expected output sample and peak.
module tb;
  import eds_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned Q28 = 64'd1 << 28;
  localparam int LIMIT_CYCLES   = 100000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int RANDOM_ITEMS   = 1150;

  typedef struct packed {
    logic signed [15:0] sample;
    logic        [14:0] peak;
  } clip_result_t;

  // Clock, reset and block ports.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_sample;
  logic        [14:0] peak_level;
  logic               cfg_we = 1'b0;
  logic         [0:0] cfg_index = REG_DELAY_LENGTH;
  logic        [15:0] cfg_data = '0;

  // Predictor state: configuration, delay line, write position, peak and tanh table.
  logic        [14:0] delay_reg = '0;
  logic        [15:0] gain_reg = '0;
  logic        [14:0] wr_pos = '0;
  logic        [14:0] peak_reg = '0;
  logic signed [15:0] echo_line [0:DELAY_DEPTH-1];
  int                 tanh_lut [0:TANH_ENTRIES];

  clip_result_t expected_q[$];
  clip_result_t oldest;
  int           err_count = 0;
  int           idle_pct = 0;
  int           items_sent = 0;
  int           stall_left = 0;
  int           cycle_count = 0;

  echo_delay_soft_clip u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .peak_level (peak_level),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // exp(arg) in Q28 from its Taylor series, each term truncated, stopping at a zero term.
  function automatic longint unsigned exp_fixed(input longint unsigned arg);
    longint unsigned acc;
    longint unsigned term;
    acc  = Q28;
    term = Q28;
    for (int n = 1; n < 64; n++) begin
      term = (term * arg) >> 28;
      term = term / longint'(n);
      if (term == 0) break;
      acc += term;
    end
    return acc;
  endfunction

  // Fill the tanh table: round(32768 * (E - 1) / (E + 1)) with E = exp(2k / entries).
  task automatic fill_tanh_lut();
    longint unsigned arg;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    for (int k = 0; k <= TANH_ENTRIES; k++) begin
      arg = (longint'(k) * 2 * Q28) / longint'(TANH_ENTRIES);
      e   = exp_fixed(arg);
      num = (e - Q28) * 32768;
      den = e + Q28;
      tanh_lut[k] = int'((num + den / 2) / den);
    end
  endtask

  // Tanh by table lookup with linear interpolation, odd-symmetric about zero.
  function automatic int tanh_interp(input int s);
    int mag;
    int pos;
    int idx;
    int frac;
    int lo;
    int hi;
    int y;
    mag = (s < 0) ? -s : s;
    pos = mag * TANH_ENTRIES;
    idx = pos >> 15;
    frac = pos & 32767;
    if (idx >= TANH_ENTRIES) begin
      y = tanh_lut[TANH_ENTRIES];
    end else begin
      lo = tanh_lut[idx];
      hi = tanh_lut[idx + 1];
      y = lo + (((hi > lo ? hi - lo : 0) * frac + 16384) >> 15);
    end
    return (s < 0) ? -y : y;
  endfunction

  // Advance the echo state by one sample and return the expected output and peak.
  function automatic clip_result_t predict_echo_clip(input logic signed [15:0] x);
    logic signed [15:0] tap;
    logic        [14:0] rd_pos;
    longint             prod;
    longint             total;
    int                 y;
    int                 mag;
    clip_result_t       res;
    rd_pos = wr_pos - delay_reg;
    tap = (delay_reg == 0) ? x : echo_line[rd_pos];
    echo_line[wr_pos] = x;
    wr_pos = wr_pos + 15'd1;
    // Echo rounded to nearest with ties upward, then the sum saturated to Q1.15.
    prod  = longint'(tap) * longint'({1'b0, gain_reg}) + 8192;
    total = longint'(x) + (prod >>> 14);
    if (total > 32767) total = 32767;
    if (total < -32768) total = -32768;
    y = tanh_interp(int'(total));
    mag = (y < 0) ? -y : y;
    if (mag > int'(peak_reg)) peak_reg = 15'(mag);
    res.sample = 16'(y);
    res.peak   = peak_reg;
    return res;
  endfunction

  // Receiver: random stall bursts while idling is enabled.
  always @(posedge clk) begin
    if (rst || idle_pct == 0) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(1, 100) <= idle_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker: each transfer on the output is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with no prediction pending: out_sample %0d", out_sample);
        err_count++;
      end else begin
        oldest = expected_q.pop_front();
        if (out_sample !== oldest.sample) begin
          $error("out_sample mismatch: expected %0d, got %0d", oldest.sample, out_sample);
          err_count++;
        end
        if (peak_level !== oldest.peak) begin
          $error("peak_level mismatch: expected %0d, got %0d", oldest.peak, peak_level);
          err_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one sample, with an optional idle burst first, and record its prediction.
  task automatic send_sample(input logic signed [15:0] x);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(predict_echo_clip(x));
    items_sent++;
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Write both registers on consecutive cycles; the block must be idle.
  task automatic set_echo(input logic [15:0] delay_word, input logic [15:0] gain_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DELAY_LENGTH;
    cfg_data  <= delay_word;
    @(posedge clk);
    delay_reg = delay_word[14:0];
    cfg_index <= REG_ECHO_GAIN;
    cfg_data  <= gain_word;
    @(posedge clk);
    gain_reg = gain_word;
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample();
    int v;
    v = $urandom_range(0, 4000);
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3, 4:    return 16'(v - 2000);
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly short delays so that the tap lands on written samples; some long and extreme.
  function automatic logic [15:0] pick_delay();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, 40));
      6, 7:             return 16'($urandom_range(41, 1200));
      8:                return 16'($urandom);
      default:          return $urandom_range(0, 1) ? 16'h7FFF : 16'hFFFF;
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h4000;
      3, 4:    return 16'($urandom_range(0, 32768));
      default: return 16'($urandom);
    endcase
  endfunction

  // No echo: plain soft clip across the sample range, including both extremes.
  task automatic test_plain_clip();
    set_echo(16'd0, 16'd0);
    send_sample(16'sh8000);
    send_sample(-16'sd32767);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(16'sd127);
    send_sample(16'sd128);
    send_sample(16'sd16384);
    send_sample(16'sh7FFF);
    drain_results();
  endtask

  // Zero delay: the tap is the current sample, so the sum is x * (1 + gain) and saturates.
  task automatic test_zero_delay();
    set_echo(16'd0, 16'h4000);
    send_sample(16'sd5000);
    send_sample(-16'sd5000);
    send_sample(16'sd20000);
    send_sample(16'sh8000);
    drain_results();
    set_echo(16'd0, 16'hFFFF);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sh7FFF);
    drain_results();
  endtask

  // Longest delay: the tap lands on entries never written, which read as zero.
  task automatic test_long_delay();
    set_echo(16'h7FFF, 16'hFFFF);
    send_sample(16'sd12345);
    send_sample(-16'sd23456);
    drain_results();
  endtask

  // Delay changed between bursts: the tap reads whatever the line holds at the new distance.
  task automatic test_delay_change();
    set_echo(16'd3, 16'h2000);
    send_sample(16'sd1000);
    send_sample(-16'sd20000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    drain_results();
    set_echo(16'd1, 16'h6000);
    send_sample(16'sd300);
    send_sample(-16'sd300);
    drain_results();
  endtask

  // Random phases, each with its own registers and amount of idling on both sides.
  task automatic test_random_stream();
    int burst;
    while (items_sent < RANDOM_ITEMS - 80) begin
      case ($urandom_range(0, 3))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        2:       idle_pct = 30;
        default: idle_pct = 55;
      endcase
      set_echo(pick_delay(), pick_gain());
      burst = $urandom_range(30, 120);
      repeat (burst) send_sample(pick_sample());
      drain_results();
    end
  endtask

  // Last part with no idling: a burst of random samples, then zeros to flush the echo tail.
  task automatic test_tail_flush();
    idle_pct = 0;
    set_echo(16'd17, 16'hC000);
    repeat (40) send_sample(pick_sample());
    repeat (40) send_sample(16'sd0);
    drain_results();
  endtask

  initial begin
    foreach (echo_line[i]) echo_line[i] = '0;
    fill_tanh_lut();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_plain_clip();
    test_zero_delay();
    test_long_delay();
    test_delay_change();
    test_random_stream();
    test_tail_flush();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/eds_pkg.sv
rtl/core/echo_delay_soft_clip.sv
dv/tb.sv
